// ===== rtl/plhm_pkg.sv =====
// ----------------------------------------------------------------------------
// plhm_pkg
// Types, constants and codes shared by the packet link health monitor.
// ----------------------------------------------------------------------------
package plhm_pkg;

   // per-message-id count table
   localparam int TYPE_ENTRIES     = 256;
   localparam int TYPE_IDX_W       = $clog2(TYPE_ENTRIES);
   localparam int TYPE_COUNT_WIDTH = 32;
   localparam logic [TYPE_COUNT_WIDTH-1:0] TYPE_COUNT_MAX = '1;

   // result count field
   localparam int RSP_COUNT_W = 32;
   localparam logic [RSP_COUNT_W-1:0] RSP_COUNT_MAX = '1;

   // running totals
   localparam int TOTAL_W = 48;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // heartbeat tracking
   localparam int TIMEOUT_W = 20;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd3000;
   localparam logic [31:0] BEAT_MIN_MS = 32'd50;
   localparam logic [31:0] BEAT_MAX_MS = 32'd60000;
   localparam logic [7:0]  HEARTBEAT_ID = 8'd0;
   localparam logic [7:0]  PEER_RESET = 8'd1;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_HB_TIMEOUT = 1'b0;

   // request action codes
   localparam logic ACT_PACKET  = 1'b0;
   localparam logic ACT_TIMEOUT = 1'b1;

   // link event codes
   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_UP   = 2'd1;
   localparam logic [1:0] EV_DOWN = 2'd2;

   typedef struct packed {
      logic        action;
      logic [31:0] now_ms;
      logic [7:0]  seq;
      logic [7:0]  msg_id;
      logic [7:0]  sender_sys;
      logic [7:0]  sender_comp;
   } req_type;

   typedef struct packed {
      logic                   link_up;
      logic [1:0]             link_event;
      logic [7:0]             peer_sys;
      logic [7:0]             peer_comp;
      logic [15:0]            beat_interval_ms;
      logic [TOTAL_W-1:0]     lost_total;
      logic [TOTAL_W-1:0]     rx_total;
      logic [RSP_COUNT_W-1:0] type_count;
   } rsp_type;

   typedef struct packed {
      logic                  rd_en;
      logic [TYPE_IDX_W-1:0] rd_idx;
      logic                  wr_en;
   } tbl_ctl_type;

endpackage

// ===== rtl/plhm_csr.sv =====
// ----------------------------------------------------------------------------
// plhm_csr
// Register port holding the heartbeat timeout.
// ----------------------------------------------------------------------------
module plhm_csr
   import plhm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [TIMEOUT_W-1:0]  timeout_ms
);

   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [TIMEOUT_W-1:0] timeout_in;
   logic                 hit;

   assign hit        = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_HB_TIMEOUT);
   assign csr_pready = 1'b1;
   assign timeout_ms = timeout_ff;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         timeout_in = csr_pwdata[TIMEOUT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         csr_prdata = CSR_DATA_W'(timeout_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

endmodule

// ===== rtl/plhm_count_table.sv =====
// ----------------------------------------------------------------------------
// plhm_count_table
// Per-message-id packet counters: synchronous memory with valid bits and
// forwarding of the last write.
// ----------------------------------------------------------------------------
module plhm_count_table
   import plhm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  tbl_ctl_type                 ctl,
   output logic [TYPE_COUNT_WIDTH-1:0] count_next
);

   logic [TYPE_COUNT_WIDTH-1:0] mem [TYPE_ENTRIES];
   logic [TYPE_COUNT_WIDTH-1:0] rd_data_ff;
   logic [TYPE_IDX_W-1:0]       idx_ff;
   logic [TYPE_ENTRIES-1:0]     valid_ff;
   logic                        fwd_valid_ff;
   logic [TYPE_IDX_W-1:0]       fwd_idx_ff;
   logic [TYPE_COUNT_WIDTH-1:0] fwd_data_ff;
   logic [TYPE_COUNT_WIDTH-1:0] count_cur;

   // the last write always holds the newest value of its entry
   always_comb begin
      priority if (fwd_valid_ff && (fwd_idx_ff == idx_ff)) begin
         count_cur = fwd_data_ff;
      end else if (valid_ff[idx_ff]) begin
         count_cur = rd_data_ff;
      end else begin
         count_cur = '0;
      end
   end

   assign count_next = (count_cur == TYPE_COUNT_MAX) ? count_cur
                                                     : count_cur + TYPE_COUNT_WIDTH'(1);

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_idx];
         idx_ff     <= ctl.rd_idx;
      end
      if (ctl.wr_en) begin
         mem[idx_ff] <= count_next;
         fwd_idx_ff  <= idx_ff;
         fwd_data_ff <= count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (ctl.wr_en) begin
         valid_ff[idx_ff] <= 1'b1;
         fwd_valid_ff     <= 1'b1;
      end
   end

endmodule

// ===== rtl/plhm_link_tracker.sv =====
// ----------------------------------------------------------------------------
// plhm_link_tracker
// Link state, heartbeat interval, sequence loss and totals; builds the result.
// ----------------------------------------------------------------------------
module plhm_link_tracker
   import plhm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  req_type                item,
   input  logic [TIMEOUT_W-1:0]   timeout_ms,
   input  logic [RSP_COUNT_W-1:0] type_count,
   output rsp_type                result
);

   logic                 connected_ff,  connected_in;
   logic [31:0]          last_beat_ff,  last_beat_in;
   logic [31:0]          prev_arr_ff,   prev_arr_in;
   logic [15:0]          interval_ff,   interval_in;
   logic                 seq_known_ff,  seq_known_in;
   logic [7:0]           prev_seq_ff,   prev_seq_in;
   logic [7:0]           peer_sys_ff,   peer_sys_in;
   logic [7:0]           peer_comp_ff,  peer_comp_in;
   logic [TOTAL_W-1:0]   lost_ff,       lost_in;
   logic [TOTAL_W-1:0]   rx_ff,         rx_in;

   logic [31:0] elapsed;
   logic [31:0] dt;
   logic [7:0]  gap;
   logic [17:0] avg_sum;
   logic [TOTAL_W:0] lost_sum;
   logic [1:0]  event_code;

   assign elapsed = item.now_ms - last_beat_ff;
   assign dt      = item.now_ms - prev_arr_ff;
   assign gap     = item.seq - (prev_seq_ff + 8'd1);
   assign avg_sum = 18'({interval_ff, 1'b0}) + 18'(interval_ff) + 18'(dt[15:0]);
   assign lost_sum = {1'b0, lost_ff} + (TOTAL_W + 1)'(gap);

   always_comb begin
      connected_in = connected_ff;
      last_beat_in = last_beat_ff;
      prev_arr_in  = prev_arr_ff;
      interval_in  = interval_ff;
      seq_known_in = seq_known_ff;
      prev_seq_in  = prev_seq_ff;
      peer_sys_in  = peer_sys_ff;
      peer_comp_in = peer_comp_ff;
      lost_in      = lost_ff;
      rx_in        = rx_ff;
      event_code   = EV_NONE;
      if (item.action == ACT_TIMEOUT) begin
         if (connected_ff && (elapsed > 32'(timeout_ms))) begin
            connected_in = 1'b0;
            interval_in  = '0;
            prev_arr_in  = '0;
            seq_known_in = 1'b0;
            event_code   = EV_DOWN;
         end
      end else begin
         if (rx_ff != TOTAL_MAX) begin
            rx_in = rx_ff + TOTAL_W'(1);
         end
         // count a forward gap below half the sequence space as loss
         if (seq_known_ff && (gap != 8'd0) && !gap[7]) begin
            lost_in = lost_sum[TOTAL_W] ? TOTAL_MAX : lost_sum[TOTAL_W-1:0];
         end
         prev_seq_in  = item.seq;
         seq_known_in = 1'b1;
         if (item.msg_id == HEARTBEAT_ID) begin
            if (!connected_ff) begin
               event_code = EV_UP;
            end
            connected_in = 1'b1;
            if ((prev_arr_ff != 32'd0) && (item.now_ms > prev_arr_ff) &&
                (dt >= BEAT_MIN_MS) && (dt < BEAT_MAX_MS)) begin
               if (interval_ff == 16'd0) begin
                  interval_in = dt[15:0];
               end else begin
                  interval_in = avg_sum[17:2];
               end
            end
            prev_arr_in  = item.now_ms;
            last_beat_in = item.now_ms;
            peer_sys_in  = item.sender_sys;
            peer_comp_in = item.sender_comp;
         end
      end
   end

   always_comb begin
      result.link_up          = connected_in;
      result.link_event       = event_code;
      result.peer_sys         = peer_sys_in;
      result.peer_comp        = peer_comp_in;
      result.beat_interval_ms = interval_in;
      result.lost_total       = lost_in;
      result.rx_total         = rx_in;
      result.type_count       = (item.action == ACT_PACKET) ? type_count : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff <= 1'b0;
         last_beat_ff <= '0;
         prev_arr_ff  <= '0;
         interval_ff  <= '0;
         seq_known_ff <= 1'b0;
         prev_seq_ff  <= '0;
         peer_sys_ff  <= PEER_RESET;
         peer_comp_ff <= PEER_RESET;
         lost_ff      <= '0;
         rx_ff        <= '0;
      end else if (advance) begin
         connected_ff <= connected_in;
         last_beat_ff <= last_beat_in;
         prev_arr_ff  <= prev_arr_in;
         interval_ff  <= interval_in;
         seq_known_ff <= seq_known_in;
         prev_seq_ff  <= prev_seq_in;
         peer_sys_ff  <= peer_sys_in;
         peer_comp_ff <= peer_comp_in;
         lost_ff      <= lost_in;
         rx_ff        <= rx_in;
      end
   end

endmodule

// ===== rtl/packet_link_health_monitor_core.sv =====
// A request is held in s1, then its result in the response register. Throughput: one
// request per cycle while responses are taken (rsp_ready low stalls both); the count
// table read port takes one message id per cycle, and the last write is forwarded to
// the next read. Reset (synchronous) clears the control state and the table valid bits
// at once; no clearing sweep, requests are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
// packet_link_health_monitor_core
// Tracks heartbeat link state, sequence loss and per-message-id counts.
// ----------------------------------------------------------------------------
module packet_link_health_monitor_core
   import plhm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic                        s1_valid_ff, s1_valid_in;
   req_type                     s1_item_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_data_ff;
   logic                        out_free;
   logic                        s1_adv;
   logic                        req_take;
   tbl_ctl_type                 tbl_ctl;
   logic [TYPE_COUNT_WIDTH-1:0] count_next;
   logic [RSP_COUNT_W-1:0]      count_sat;
   logic [TIMEOUT_W-1:0]        timeout_ms;
   rsp_type                     result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_take  = req_valid && req_ready;

   assign tbl_ctl.rd_en  = req_take;
   assign tbl_ctl.rd_idx = req_data.msg_id[TYPE_IDX_W-1:0];
   assign tbl_ctl.wr_en  = s1_adv && (s1_item_ff.action == ACT_PACKET);

   // clamp wide table entries to the result field
   assign count_sat = (64'(count_next) > 64'(RSP_COUNT_MAX)) ? RSP_COUNT_MAX
                                                             : RSP_COUNT_W'(count_next);

   plhm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timeout_ms  (timeout_ms)
   );

   plhm_count_table u_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tbl_ctl),
      .count_next (count_next)
   );

   plhm_link_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_adv),
      .item       (s1_item_ff),
      .timeout_ms (timeout_ms),
      .type_count (count_sat),
      .result     (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
